// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

    localparam int VALUE_W       = 32;
    localparam int MODE_W        = 4;
    localparam int STATUS_W      = 2;
    localparam int FILL_W        = 5;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR     = 4'd0,
        MODE_EMPTY_Q   = 4'd1,
        MODE_PEEK_HEAD = 4'd2,
        MODE_PEEK_TAIL = 4'd3,
        MODE_DROP_HEAD = 4'd4,
        MODE_DROP_TAIL = 4'd5,
        MODE_TAKE_HEAD = 4'd6,
        MODE_TAKE_TAIL = 4'd7,
        MODE_OVW_HEAD  = 4'd8,
        MODE_OVW_TAIL  = 4'd9,
        MODE_PUSH_HEAD = 4'd10,
        MODE_PUSH_TAIL = 4'd11
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

// ===== rtl/bdq_store.sv =====
module bdq_store
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic               aclk,
    input  logic               en,
    input  logic               we,
    input  logic [IDX_W-1:0]   addr,
    input  logic [VALUE_W-1:0] wdata,
    output logic [VALUE_W-1:0] rdata
);

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bounded_deque.sv =====
// Channel   Direction  Ports                                             Handshake
// request   in         s_mode, s_value                                   s_valid / s_ready
// result    out        m_read_value, m_status, m_is_empty, m_fill_count  m_valid / m_ready
//
// One request per cycle unless the result side stalls; each result is registered in the
// read stage, then in the output register. The ring sits in a single-port memory, read or
// written at most once per request. Reset (aresetn low, synchronous) empties the queue;
// no clearing pass. A stalled result holds the output register; one more request is then
// held in the read stage before s_ready drops.
module bounded_deque
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [MODE_W-1:0]          s_mode,
    input  logic signed [VALUE_W-1:0]  s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [VALUE_W-1:0]  m_read_value,
    output logic [STATUS_W-1:0]        m_status,
    output logic                       m_is_empty,
    output logic [FILL_W-1:0]          m_fill_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [IDX_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic                s1_valid_reg;
    logic                s1_rd_sel_reg;
    status_t             s1_status_reg;
    logic                s1_empty_reg;
    logic [FILL_W-1:0]   s1_fill_reg;

    logic                m_valid_reg;
    logic [VALUE_W-1:0]  m_read_value_reg;
    status_t             m_status_reg;
    logic                m_is_empty_reg;
    logic [FILL_W-1:0]   m_fill_reg;

    logic                accept;
    logic                advance;
    mode_t               mode;
    status_t             status;
    logic                rd_sel;
    logic                mem_en;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_addr;
    logic [VALUE_W-1:0]  mem_rdata;

    logic [SUM_W-1:0]    push_sum, tail_sum, push_wrap, tail_wrap;
    logic [IDX_W-1:0]    head_inc, head_dec;
    logic                is_empty_now, is_full_now;
    logic [FILL_W+CNT_W-1:0] fill_wide;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign mode    = mode_t'(s_mode);

    assign push_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_sum  = push_sum - SUM_W'(1);
    assign push_wrap = (push_sum >= SUM_W'(DEPTH)) ? push_sum - SUM_W'(DEPTH) : push_sum;
    assign tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
    assign head_inc  = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign head_dec  = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);

    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        status     = STATUS_OK;
        rd_sel     = 1'b0;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = head_reg;
        case (mode)
            MODE_CLEAR: begin
                head_next  = '0;
                count_next = '0;
            end
            MODE_PEEK_HEAD, MODE_PEEK_TAIL, MODE_TAKE_HEAD, MODE_TAKE_TAIL,
            MODE_DROP_HEAD, MODE_DROP_TAIL, MODE_OVW_HEAD, MODE_OVW_TAIL: begin
                if (is_empty_now) begin
                    status = STATUS_EMPTY;
                end else begin
                    mem_addr = s_mode[0] ? tail_wrap[IDX_W-1:0] : head_reg;
                    if (mode == MODE_PEEK_HEAD || mode == MODE_PEEK_TAIL ||
                        mode == MODE_TAKE_HEAD || mode == MODE_TAKE_TAIL) begin
                        rd_sel = 1'b1;
                        mem_en = 1'b1;
                    end
                    if (mode == MODE_OVW_HEAD || mode == MODE_OVW_TAIL) begin
                        mem_en = 1'b1;
                        mem_we = 1'b1;
                    end
                    if (mode == MODE_DROP_HEAD || mode == MODE_DROP_TAIL ||
                        mode == MODE_TAKE_HEAD || mode == MODE_TAKE_TAIL) begin
                        count_next = count_reg - CNT_W'(1);
                        if (!s_mode[0]) begin
                            head_next = head_inc;
                        end
                        if (count_reg == CNT_W'(1)) begin
                            head_next = '0;
                        end
                    end
                end
            end
            MODE_PUSH_HEAD, MODE_PUSH_TAIL: begin
                if (is_full_now) begin
                    status = STATUS_FULL;
                end else begin
                    mem_en     = 1'b1;
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    if (s_mode[0]) begin
                        mem_addr = push_wrap[IDX_W-1:0];
                    end else begin
                        mem_addr  = head_dec;
                        head_next = head_dec;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign fill_wide = {{FILL_W{1'b0}}, count_next};

    bdq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .en    (accept && mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (s_value),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                head_reg  <= head_next;
                count_reg <= count_next;
            end
            s1_valid_reg <= accept || (s1_valid_reg && !advance);
            m_valid_reg  <= advance || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_rd_sel_reg <= rd_sel;
            s1_status_reg <= status;
            s1_empty_reg  <= (count_next == '0);
            s1_fill_reg   <= fill_wide[FILL_W-1:0];
        end
        if (advance) begin
            m_read_value_reg <= s1_rd_sel_reg ? mem_rdata : '0;
            m_status_reg     <= s1_status_reg;
            m_is_empty_reg   <= s1_empty_reg;
            m_fill_reg       <= s1_fill_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_status     = m_status_reg;
    assign m_is_empty   = m_is_empty_reg;
    assign m_fill_count = m_fill_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= IDX_W'(DEPTH - 1))
        else $error("head index outside ring");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == '0))
        else $error("empty queue with head off origin");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted request lost from read stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_status_reg)))
        else $error("stalled result changed");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bdq_pkg::*;

    localparam int RING_DEPTH   = DEPTH_DEFAULT;
    localparam int IDX_W        = $clog2(RING_DEPTH);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 700;

    typedef logic [IDX_W-1:0] slot_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        status_t                   status;
        logic                      is_empty;
        logic [FILL_W-1:0]         fill_count;
    } deque_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [MODE_W-1:0]         s_mode = '0;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_read_value;
    logic [STATUS_W-1:0]       m_status;
    logic                      m_is_empty;
    logic [FILL_W-1:0]         m_fill_count;

    logic signed [VALUE_W-1:0] ring_model [RING_DEPTH];
    slot_t                     head_idx = '0;
    logic [FILL_W-1:0]         fill_cnt = '0;

    deque_result_t awaited_results [$];

    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned requests_sent = 0;
    int unsigned results_seen = 0;
    int unsigned full_refusals = 0;
    int unsigned empty_refusals = 0;
    int unsigned peak_fill = 0;
    int          hold_req = 0;
    bit          quiet = 1'b0;

    bounded_deque #(
        .DEPTH(RING_DEPTH)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_value(m_read_value),
        .m_status    (m_status),
        .m_is_empty  (m_is_empty),
        .m_fill_count(m_fill_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic deque_result_t deque_apply(input logic [MODE_W-1:0] mode,
                                                  input logic signed [VALUE_W-1:0] value);
        deque_result_t r;
        int            slot;
        r.read_value = '0;
        r.status     = STATUS_OK;
        slot         = int'(head_idx);
        if (mode[0] && fill_cnt != 0) begin
            slot = (int'(head_idx) + int'(fill_cnt) - 1) % RING_DEPTH;
        end
        if (mode == MODE_CLEAR) begin
            head_idx = '0;
            fill_cnt = '0;
        end else if (mode inside {[MODE_PEEK_HEAD:MODE_OVW_TAIL]}) begin
            if (fill_cnt == 0) begin
                r.status = STATUS_EMPTY;
                empty_refusals++;
            end else begin
                case (mode)
                    MODE_PEEK_HEAD, MODE_PEEK_TAIL: begin
                        r.read_value = ring_model[slot];
                    end
                    MODE_OVW_HEAD, MODE_OVW_TAIL: begin
                        ring_model[slot] = value;
                    end
                    default: begin
                        if (mode == MODE_TAKE_HEAD || mode == MODE_TAKE_TAIL) begin
                            r.read_value = ring_model[slot];
                        end
                        if (!mode[0]) begin
                            head_idx = slot_t'((int'(head_idx) + 1) % RING_DEPTH);
                        end
                        fill_cnt = fill_cnt - 1'b1;
                        if (fill_cnt == 0) begin
                            head_idx = '0;
                        end
                    end
                endcase
            end
        end else if (mode == MODE_PUSH_HEAD || mode == MODE_PUSH_TAIL) begin
            if (fill_cnt >= RING_DEPTH) begin
                r.status = STATUS_FULL;
                full_refusals++;
            end else if (mode[0]) begin
                ring_model[(int'(head_idx) + int'(fill_cnt)) % RING_DEPTH] = value;
                fill_cnt = fill_cnt + 1'b1;
            end else begin
                head_idx = slot_t'((int'(head_idx) + RING_DEPTH - 1) % RING_DEPTH);
                ring_model[head_idx] = value;
                fill_cnt = fill_cnt + 1'b1;
            end
        end
        r.is_empty   = (fill_cnt == 0);
        r.fill_count = fill_cnt;
        if (fill_cnt > peak_fill) begin
            peak_fill = fill_cnt;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return MODE_CLEAR;
        if (r < 6) return MODE_W'($urandom_range(12, 15));
        if (r < 9) return MODE_EMPTY_Q;
        if (r < (filling ? 62 : 28)) begin
            return $urandom_range(0, 1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD;
        end
        return MODE_W'($urandom_range(int'(MODE_PEEK_HEAD), int'(MODE_OVW_TAIL)));
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 24))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic issue_request(input logic [MODE_W-1:0] mode,
                                 input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_mode  <= mode;
        s_value <= value;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        awaited_results.push_back(deque_apply(mode, value));
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // result side: random stalls, plus a long hold when requested
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 25) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge aclk) begin
        deque_result_t want;
        if (m_valid && m_ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                note_failure($sformatf("result %0d arrived with no request outstanding",
                                       results_seen));
            end else begin
                want = awaited_results.pop_front();
                if ({m_read_value, m_status, m_is_empty, m_fill_count} !== want) begin
                    note_failure($sformatf(
                        "result %0d: expected value %0d status %0d empty %0b count %0d, got %0d %0d %0b %0d",
                        results_seen, want.read_value, want.status, want.is_empty,
                        want.fill_count, m_read_value, m_status, m_is_empty, m_fill_count));
                end
            end
        end
    end

    task automatic test_directed();
        issue_request(MODE_CLEAR, 32'sd5);
        issue_request(MODE_EMPTY_Q, '0);
        for (int m = MODE_PEEK_HEAD; m <= MODE_OVW_TAIL; m++) begin
            issue_request(MODE_W'(m), 32'sh5a5a_a5a5);
        end
        issue_request(MODE_PUSH_HEAD, 32'sh7fff_ffff);
        issue_request(MODE_PUSH_TAIL, 32'sh8000_0000);
        issue_request(MODE_PEEK_HEAD, '0);
        issue_request(MODE_PEEK_TAIL, '0);
        issue_request(MODE_OVW_HEAD, -32'sd1);
        issue_request(MODE_OVW_TAIL, '0);
        issue_request(MODE_EMPTY_Q, '0);
        issue_request(4'd12, 32'sh1234_5678);
        issue_request(4'd15, -32'sd1);
        issue_request(MODE_TAKE_TAIL, '0);
        issue_request(MODE_TAKE_HEAD, '0);
        issue_request(MODE_PUSH_TAIL, 32'sd1);
        issue_request(MODE_CLEAR, '0);
        issue_request(MODE_EMPTY_Q, '0);
    endtask

    task automatic test_full_and_wrap();
        issue_request(MODE_PUSH_TAIL, pick_value());
        issue_request(MODE_DROP_HEAD, '0);
        for (int i = 0; i < RING_DEPTH; i++) begin
            issue_request($urandom_range(0, 1) ? MODE_PUSH_TAIL : MODE_PUSH_HEAD,
                          pick_value());
        end
        issue_request(MODE_PUSH_HEAD, pick_value());
        issue_request(MODE_PUSH_TAIL, pick_value());
        issue_request(MODE_PEEK_HEAD, '0);
        issue_request(MODE_PEEK_TAIL, '0);
        issue_request(MODE_OVW_HEAD, pick_value());
        issue_request(MODE_OVW_TAIL, pick_value());
        for (int i = 0; i < RING_DEPTH; i++) begin
            issue_request(MODE_W'($urandom_range(int'(MODE_DROP_HEAD),
                                                 int'(MODE_TAKE_TAIL))), pick_value());
        end
        issue_request(MODE_TAKE_HEAD, '0);
        issue_request(MODE_DROP_TAIL, '0);
    endtask

    task automatic test_backpressure();
        quiet    = 1'b1;
        hold_req = 150;
        for (int i = 0; i < 40; i++) begin
            issue_request(pick_mode(1'b1), pick_value());
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int  phase_len;
        bit  filling;
        int  issued;
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            phase_len = $urandom_range(15, 60);
            filling   = (fill_cnt < RING_DEPTH / 2) ? ($urandom_range(0, 3) != 0)
                                                    : ($urandom_range(0, 3) == 0);
            quiet     = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < phase_len; i++) begin
                issue_request(pick_mode(filling), pick_value());
            end
            issued += phase_len;
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_and_wrap();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        if (awaited_results.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", awaited_results.size()));
        end
        $display("Sent %0d requests and checked %0d results over %0d cycles.",
                 requests_sent, results_seen, cycle_count);
        $display("Saw %0d full refusals, %0d empty refusals, peak fill %0d of %0d.",
                 full_refusals, empty_refusals, peak_fill, RING_DEPTH);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
